// ----- rtl/ansi_sgr_cursor_encoder_macros.svh -----
// Assertion shorthands used by the checker of this block.
`ifndef ANSI_SGR_CURSOR_ENCODER_MACROS_SVH
`define ANSI_SGR_CURSOR_ENCODER_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define ASE_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, no reset qualifier.
`define ASE_ASSERT_NEXT(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ----- rtl/ase_pkg.sv -----
// -----------------------------------------------------------------------------
// ase_pkg
// Types, byte codes and helpers of the ANSI SGR/cursor encoder.
// -----------------------------------------------------------------------------
package ase_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_MOVE  = 2'd1,
      FUNC_STYLE = 2'd2,
      FUNC_SYNC  = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] attr;
      logic [7:0] char_code;
      logic       cursor_visible;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // Byte slots of one item, sent in ascending order, each enabled by a mask bit.
   localparam int SL_A_ESC    = 0;
   localparam int SL_A_LB     = 1;
   localparam int SL_A_ZERO   = 2;
   localparam int SL_A_ZSEP   = 3;
   localparam int SL_BOLD_1   = 4;
   localparam int SL_BOLD_2   = 5;
   localparam int SL_BOLD_SEP = 6;
   localparam int SL_BLINK_2  = 7;
   localparam int SL_BLINK_5  = 8;
   localparam int SL_BLINK_SEP = 9;
   localparam int SL_FG_3     = 10;
   localparam int SL_FG_D     = 11;
   localparam int SL_FG_SEP   = 12;
   localparam int SL_BG_4     = 13;
   localparam int SL_BG_D     = 14;
   localparam int SL_BG_M     = 15;
   localparam int SL_P_ESC    = 16;
   localparam int SL_P_LB     = 17;
   localparam int SL_R_H      = 18;
   localparam int SL_R_T      = 19;
   localparam int SL_R_O      = 20;
   localparam int SL_P_SEP    = 21;
   localparam int SL_C_H      = 22;
   localparam int SL_C_T      = 23;
   localparam int SL_C_O      = 24;
   localparam int SL_P_H      = 25;
   localparam int SL_CHAR     = 26;
   localparam int SL_S_ESC    = 27;
   localparam int SL_S_LB     = 28;
   localparam int SL_S_Q      = 29;
   localparam int SL_S_2      = 30;
   localparam int SL_S_5      = 31;
   localparam int SL_S_HL     = 32;
   localparam int SLOT_COUNT  = 33;
   localparam int SLOT_W      = 6;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_LB   = 8'h5B;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_TWO  = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FOUR = 8'h34;
   localparam logic [7:0] CH_FIVE = 8'h35;
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] CH_QM   = 8'h3F;
   localparam logic [7:0] CH_SHOW = 8'h68;
   localparam logic [7:0] CH_HIDE = 8'h6C;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0] ATTR_BLINK = 8'h80;
   localparam logic [7:0] ATTR_BOLD  = 8'h08;
   localparam logic [7:0] ATTR_FG    = 8'h07;

   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      logic       bold;
      logic       blink;
      logic [2:0] fg;
      logic [2:0] bg;
      logic [3:0] r_h;
      logic [3:0] r_t;
      logic [3:0] r_o;
      logic [3:0] c_h;
      logic [3:0] c_t;
      logic [3:0] c_o;
      logic [7:0] chr;
      logic       vis;
   } job_type;

   // PC colour order to ANSI colour numbers
   function automatic logic [2:0] pc_to_ansi(input logic [2:0] c);
      logic [2:0] r;
      case (c)
         3'd0:    r = 3'd0;
         3'd1:    r = 3'd4;
         3'd2:    r = 3'd2;
         3'd3:    r = 3'd6;
         3'd4:    r = 3'd1;
         3'd5:    r = 3'd5;
         3'd6:    r = 3'd3;
         default: r = 3'd7;
      endcase
      return r;
   endfunction

   // Decimal digits of v (1..256): {hundreds, tens, ones}
   function automatic logic [11:0] to_dec(input logic [8:0] v);
      logic [3:0] h;
      logic [3:0] t;
      logic [7:0] rem;
      logic [7:0] o;
      h = (v >= 9'd200) ? 4'd2 : ((v >= 9'd100) ? 4'd1 : 4'd0);
      rem = 8'(v - 9'(h) * 9'd100);
      t = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= 8'(k * 10)) t = t + 4'd1;
      end
      o = rem - 8'(t) * 8'd10;
      return {h, t, o[3:0]};
   endfunction

endpackage

// ----- rtl/ansi_sgr_cursor_encoder.sv -----
// -----------------------------------------------------------------------------
// ansi_sgr_cursor_encoder
// Encodes text-mode screen updates as an ANSI terminal byte stream.
// -----------------------------------------------------------------------------
//   channel   direction  handshake        payload
//   req       in         req_push/full    ase_pkg::req_type
//   rsp       out        rsp_pop/empty    ase_pkg::rsp_type
//
// One result byte per cycle from the back end's slot walker while the receiver
// keeps taking bytes; an item holds the back end until all its bytes are sent.
// The first byte passes through the job queue and the result register before
// it reaches the result ports. Items with no bytes are never queued.
// The job queue lets the front take items while the back end still sends.
// Reset is synchronous; the block is ready once it drops.
module ansi_sgr_cursor_encoder #(
   parameter int QUEUE_DEPTH = ase_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ase_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ase_pkg::rsp_type rsp_data
);
   import ase_pkg::*;

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_data, job_head;

   ase_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_data)
   );

   ase_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .head      (job_head)
   );

   ase_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/ase_front.sv -----
// -----------------------------------------------------------------------------
// ase_front
// Takes screen updates, checks them against the tracked terminal state and
// turns each that needs bytes into a byte-slot job for the back end.
// -----------------------------------------------------------------------------
module ase_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ase_pkg::req_type req_data,
   output logic             req_full,
   input  logic             job_full,
   output logic             job_push,
   output ase_pkg::job_type job_data
);
   import ase_pkg::*;

   logic       attr_known_ff, attr_known_in;
   logic [7:0] current_attr_ff, current_attr_in;
   logic       bold_on_ff, bold_on_in;
   logic       blink_on_ff, blink_on_in;
   logic [2:0] fg_color_ff, fg_color_in;
   logic [2:0] bg_color_ff, bg_color_in;
   logic       pos_known_ff, pos_known_in;
   logic [7:0] tracked_row_ff, tracked_row_in;
   logic [8:0] tracked_col_ff, tracked_col_in;
   logic       style_known_ff, style_known_in;
   logic       cursor_shown_ff, cursor_shown_in;

   logic       accept;
   logic       is_write, is_move, is_style;
   logic       bold, blink, full_seq, attr_chg;
   logic [2:0] fg, bg;
   logic       p_bold, p_blink, p_fg, p_bg, p_attr, p_pos, p_style;
   logic [8:0] r1, c1;
   logic [11:0] rd, cd;
   logic [7:0] chr;
   job_type    job;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   assign is_write = (req_data.func == FUNC_WRITE);
   assign is_move  = (req_data.func == FUNC_MOVE);
   assign is_style = (req_data.func == FUNC_STYLE);

   assign fg    = pc_to_ansi(req_data.attr[2:0]);
   assign bg    = pc_to_ansi(req_data.attr[6:4]);
   assign bold  = |(req_data.attr & ATTR_BOLD);
   assign blink = |(req_data.attr & ATTR_BLINK);

   assign attr_chg = !attr_known_ff || (current_attr_ff != req_data.attr);
   assign full_seq = is_write && !attr_known_ff;
   assign p_bold   = is_write && (full_seq ? bold  : (bold != bold_on_ff));
   assign p_blink  = is_write && (full_seq ? blink : (blink != blink_on_ff));
   assign p_fg     = is_write && (full_seq || (fg != fg_color_ff));
   assign p_bg     = is_write && (full_seq || (bg != bg_color_ff));
   assign p_attr   = full_seq || p_bold || p_blink || p_fg || p_bg;

   assign p_pos = (is_write || is_move) && (!pos_known_ff
                  || (tracked_row_ff != req_data.row)
                  || (tracked_col_ff != {1'b0, req_data.col}));
   assign p_style = is_style && (!style_known_ff
                    || (cursor_shown_ff != req_data.cursor_visible));

   assign r1 = {1'b0, req_data.row} + 9'd1;
   assign c1 = {1'b0, req_data.col} + 9'd1;
   assign rd = to_dec(r1);
   assign cd = to_dec(c1);

   assign chr = ((req_data.char_code < CH_SPACE) || (req_data.char_code == CH_DEL))
                ? CH_DOT : req_data.char_code;

   always_comb begin
      job = '0;
      job.mask[SL_A_ESC]     = p_attr;
      job.mask[SL_A_LB]      = p_attr;
      job.mask[SL_A_ZERO]    = full_seq;
      job.mask[SL_A_ZSEP]    = full_seq;
      job.mask[SL_BOLD_1]    = p_bold;
      job.mask[SL_BOLD_2]    = p_bold && !bold;
      job.mask[SL_BOLD_SEP]  = p_bold;
      job.mask[SL_BLINK_2]   = p_blink && !blink;
      job.mask[SL_BLINK_5]   = p_blink;
      job.mask[SL_BLINK_SEP] = p_blink;
      job.mask[SL_FG_3]      = p_fg;
      job.mask[SL_FG_D]      = p_fg;
      job.mask[SL_FG_SEP]    = p_fg;
      job.mask[SL_BG_4]      = p_bg;
      job.mask[SL_BG_D]      = p_bg;
      job.mask[SL_BG_M]      = p_bg;
      job.mask[SL_P_ESC]     = p_pos;
      job.mask[SL_P_LB]      = p_pos;
      job.mask[SL_R_H]       = p_pos && (r1 >= 9'd100);
      job.mask[SL_R_T]       = p_pos && (r1 >= 9'd10);
      job.mask[SL_R_O]       = p_pos;
      job.mask[SL_P_SEP]     = p_pos;
      job.mask[SL_C_H]       = p_pos && (c1 >= 9'd100);
      job.mask[SL_C_T]       = p_pos && (c1 >= 9'd10);
      job.mask[SL_C_O]       = p_pos;
      job.mask[SL_P_H]       = p_pos;
      job.mask[SL_CHAR]      = is_write;
      job.mask[SL_S_ESC]     = p_style;
      job.mask[SL_S_LB]      = p_style;
      job.mask[SL_S_Q]       = p_style;
      job.mask[SL_S_2]       = p_style;
      job.mask[SL_S_5]       = p_style;
      job.mask[SL_S_HL]      = p_style;
      job.bold  = bold;
      job.blink = blink;
      job.fg    = fg;
      job.bg    = bg;
      job.r_h   = rd[11:8];
      job.r_t   = rd[7:4];
      job.r_o   = rd[3:0];
      job.c_h   = cd[11:8];
      job.c_t   = cd[7:4];
      job.c_o   = cd[3:0];
      job.chr   = chr;
      job.vis   = req_data.cursor_visible;
   end

   assign job_push = accept && (|job.mask);
   assign job_data = job;

   always_comb begin
      attr_known_in   = attr_known_ff;
      current_attr_in = current_attr_ff;
      bold_on_in      = bold_on_ff;
      blink_on_in     = blink_on_ff;
      fg_color_in     = fg_color_ff;
      bg_color_in     = bg_color_ff;
      pos_known_in    = pos_known_ff;
      tracked_row_in  = tracked_row_ff;
      tracked_col_in  = tracked_col_ff;
      style_known_in  = style_known_ff;
      cursor_shown_in = cursor_shown_ff;
      if (accept) begin
         case (req_data.func)
            FUNC_WRITE: begin
               if (attr_chg) begin
                  attr_known_in   = 1'b1;
                  current_attr_in = req_data.attr;
                  bold_on_in      = bold;
                  blink_on_in     = blink;
                  fg_color_in     = fg;
                  bg_color_in     = bg;
               end
               pos_known_in   = 1'b1;
               tracked_row_in = req_data.row;
               tracked_col_in = c1;
            end
            FUNC_MOVE: begin
               pos_known_in   = 1'b1;
               tracked_row_in = req_data.row;
               tracked_col_in = {1'b0, req_data.col};
            end
            FUNC_STYLE: begin
               style_known_in  = 1'b1;
               cursor_shown_in = req_data.cursor_visible;
            end
            default: begin
               attr_known_in  = 1'b0;
               pos_known_in   = 1'b0;
               style_known_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_known_ff   <= 1'b0;
         current_attr_ff <= '0;
         bold_on_ff      <= 1'b0;
         blink_on_ff     <= 1'b0;
         fg_color_ff     <= '0;
         bg_color_ff     <= '0;
         pos_known_ff    <= 1'b0;
         tracked_row_ff  <= '0;
         tracked_col_ff  <= '0;
         style_known_ff  <= 1'b0;
         cursor_shown_ff <= 1'b0;
      end else begin
         attr_known_ff   <= attr_known_in;
         current_attr_ff <= current_attr_in;
         bold_on_ff      <= bold_on_in;
         blink_on_ff     <= blink_on_in;
         fg_color_ff     <= fg_color_in;
         bg_color_ff     <= bg_color_in;
         pos_known_ff    <= pos_known_in;
         tracked_row_ff  <= tracked_row_in;
         tracked_col_ff  <= tracked_col_in;
         style_known_ff  <= style_known_in;
         cursor_shown_ff <= cursor_shown_in;
      end
   end

endmodule

// ----- rtl/ase_queue.sv -----
// -----------------------------------------------------------------------------
// ase_queue
// Short job queue between the front and the back end.
// -----------------------------------------------------------------------------
module ase_queue #(
   parameter int DEPTH = ase_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ase_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output ase_pkg::job_type head
);
   import ase_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/ase_back.sv -----
// -----------------------------------------------------------------------------
// ase_back
// Walks the enabled byte slots of each job into the result register, one byte
// a cycle while that register is empty or its byte is taken.
// -----------------------------------------------------------------------------
module ase_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  ase_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ase_pkg::rsp_type rsp_data
);
   import ase_pkg::*;

   logic                  busy_ff, busy_in;
   job_type               job_ff, job_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   job_type               cur;
   logic [SLOT_COUNT-1:0] rest;
   logic [SLOT_W-1:0]     slot;
   logic                  advance, step;
   logic [7:0]            b;

   assign cur     = busy_ff ? job_ff : job_head;
   assign advance = !out_valid_ff || rsp_pop;
   assign step    = advance && (busy_ff || !job_empty);
   assign job_pop = step && !busy_ff;

   always_comb begin
      slot = '0;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (cur.mask[k]) slot = SLOT_W'(k);
      end
   end

   always_comb begin
      rest = cur.mask;
      rest[slot] = 1'b0;
   end

   always_comb begin
      case (int'(slot))
         SL_A_ESC, SL_P_ESC, SL_S_ESC: b = CH_ESC;
         SL_A_LB, SL_P_LB, SL_S_LB:    b = CH_LB;
         SL_A_ZERO:    b = CH_ZERO;
         SL_A_ZSEP, SL_P_SEP: b = CH_SEMI;
         SL_BOLD_1:    b = cur.bold ? CH_ONE : CH_TWO;
         SL_BOLD_2, SL_BLINK_2, SL_S_2: b = CH_TWO;
         // last part of an SGR sequence closes with 'm'
         SL_BOLD_SEP:  b = (cur.mask[SL_BLINK_5] || cur.mask[SL_FG_3]
                            || cur.mask[SL_BG_4]) ? CH_SEMI : CH_M;
         SL_BLINK_5, SL_S_5: b = CH_FIVE;
         SL_BLINK_SEP: b = (cur.mask[SL_FG_3] || cur.mask[SL_BG_4]) ? CH_SEMI : CH_M;
         SL_FG_3:      b = CH_THREE;
         SL_FG_D:      b = CH_ZERO + {5'd0, cur.fg};
         SL_FG_SEP:    b = cur.mask[SL_BG_4] ? CH_SEMI : CH_M;
         SL_BG_4:      b = CH_FOUR;
         SL_BG_D:      b = CH_ZERO + {5'd0, cur.bg};
         SL_BG_M:      b = CH_M;
         SL_R_H:       b = CH_ZERO + {4'd0, cur.r_h};
         SL_R_T:       b = CH_ZERO + {4'd0, cur.r_t};
         SL_R_O:       b = CH_ZERO + {4'd0, cur.r_o};
         SL_C_H:       b = CH_ZERO + {4'd0, cur.c_h};
         SL_C_T:       b = CH_ZERO + {4'd0, cur.c_t};
         SL_C_O:       b = CH_ZERO + {4'd0, cur.c_o};
         SL_P_H:       b = CH_H;
         SL_CHAR:      b = cur.chr;
         SL_S_Q:       b = CH_QM;
         SL_S_HL:      b = cur.vis ? CH_SHOW : CH_HIDE;
         default:      b = CH_DOT;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (step) begin
         job_in          = cur;
         job_in.mask     = rest;
         busy_in         = |rest;
         out_valid_in    = 1'b1;
         out_in.out_byte = b;
         out_in.last_byte = ~|rest;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/ase_checker.sv -----
// -----------------------------------------------------------------------------
// ase_checker
// Port-level checks of the encoder, bound to the top level.
// -----------------------------------------------------------------------------
`include "ansi_sgr_cursor_encoder_macros.svh"

module ase_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input ase_pkg::req_type req_data,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input ase_pkg::rsp_type rsp_data
);
   import ase_pkg::*;

   // reset leaves no result waiting and the input open
   `ASE_ASSERT_NEXT(a_reset_clear, clock, reset, rsp_empty && !req_full)
   // hold a waiting word until taken
   `ASE_ASSERT_NEXT(a_rsp_hold, clock, !reset && !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_data))
   // no sequence ends on an escape byte
   `ASE_ASSERT_IMPLY(a_last_not_esc, clock, reset, !rsp_empty && rsp_data.last_byte,
      rsp_data.out_byte != CH_ESC)

endmodule

bind ansi_sgr_cursor_encoder ase_checker u_ase_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_data  (req_data),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_top.sv -----
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ANSI SGR/cursor encoder: a directed table of
// screen updates, then random write runs, moves, visibility changes and
// resyncs, with random sender bursts and receiver stalls. Every byte is
// compared with a behavioural model of the encoder.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ase_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIR_COUNT = 22;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   ansi_sgr_cursor_encoder DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // encoder model state
   logic       m_attr_known, m_pos_known, m_style_known, m_shown;
   logic [7:0] m_attr, m_row;
   logic       m_bold, m_blink;
   logic [2:0] m_fg, m_bg;
   logic [8:0] m_col;

   rsp_type    byte_queue[$];
   logic [7:0] item_bytes[$];
   int         mismatches = 0;
   int         idle_cycles = 0;
   bit         feeding_done = 0;
   bit         hold_off = 0;

   function automatic logic [2:0] colour_of(input logic [2:0] c);
      logic [2:0] lut [8];
      lut = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
      return lut[c];
   endfunction

   task automatic push_dec(input int v);
      if (v >= 100) item_bytes.push_back(8'(CH_ZERO + (v / 100) % 10));
      if (v >= 10) item_bytes.push_back(8'(CH_ZERO + (v / 10) % 10));
      item_bytes.push_back(8'(CH_ZERO + v % 10));
   endtask

   task automatic encode_position(input logic [7:0] r, input logic [7:0] c);
      if (m_pos_known && m_row == r && m_col == {1'b0, c}) return;
      item_bytes.push_back(CH_ESC);
      item_bytes.push_back(CH_LB);
      push_dec(int'(r) + 1);
      item_bytes.push_back(CH_SEMI);
      push_dec(int'(c) + 1);
      item_bytes.push_back(CH_H);
      m_row = r;
      m_col = {1'b0, c};
      m_pos_known = 1'b1;
   endtask

   task automatic encode_attr(input logic [7:0] a);
      logic [2:0] fg, bg;
      logic       bo, bl;
      int         start;
      if (m_attr_known && m_attr == a) return;
      fg = colour_of(a[2:0]);
      bg = colour_of(a[6:4]);
      bo = a[3];
      bl = a[7];
      start = item_bytes.size();
      item_bytes.push_back(CH_ESC);
      item_bytes.push_back(CH_LB);
      if (!m_attr_known) begin
         item_bytes.push_back(CH_ZERO); item_bytes.push_back(CH_SEMI);
         if (bo) begin item_bytes.push_back(CH_ONE); item_bytes.push_back(CH_SEMI); end
         if (bl) begin item_bytes.push_back(CH_FIVE); item_bytes.push_back(CH_SEMI); end
         item_bytes.push_back(CH_THREE); item_bytes.push_back(8'(CH_ZERO + fg));
         item_bytes.push_back(CH_SEMI);
         item_bytes.push_back(CH_FOUR); item_bytes.push_back(8'(CH_ZERO + bg));
         item_bytes.push_back(CH_M);
      end else begin
         if (m_bold != bo) begin
            if (bo) item_bytes.push_back(CH_ONE);
            else begin item_bytes.push_back(CH_TWO); item_bytes.push_back(CH_TWO); end
            item_bytes.push_back(CH_SEMI);
         end
         if (m_blink != bl) begin
            if (!bl) item_bytes.push_back(CH_TWO);
            item_bytes.push_back(CH_FIVE); item_bytes.push_back(CH_SEMI);
         end
         if (m_fg != fg) begin
            item_bytes.push_back(CH_THREE); item_bytes.push_back(8'(CH_ZERO + fg));
            item_bytes.push_back(CH_SEMI);
         end
         if (m_bg != bg) begin
            item_bytes.push_back(CH_FOUR); item_bytes.push_back(8'(CH_ZERO + bg));
            item_bytes.push_back(CH_SEMI);
         end
         if (item_bytes.size() > start + 2) item_bytes[item_bytes.size() - 1] = CH_M;
         else while (item_bytes.size() > start) void'(item_bytes.pop_back());
      end
      m_bold = bo;
      m_blink = bl;
      m_fg = fg;
      m_bg = bg;
      m_attr = a;
      m_attr_known = 1'b1;
   endtask

   // Work out the bytes of one update and queue them as expected words.
   task automatic encode_update(input req_type rq);
      rsp_type w;
      item_bytes.delete();
      case (func_type'(rq.func))
         FUNC_WRITE: begin
            encode_attr(rq.attr);
            encode_position(rq.row, rq.col);
            if (rq.char_code < CH_SPACE || rq.char_code == CH_DEL)
               item_bytes.push_back(CH_DOT);
            else
               item_bytes.push_back(rq.char_code);
            m_col = m_col + 9'd1;
         end
         FUNC_MOVE: encode_position(rq.row, rq.col);
         FUNC_STYLE: begin
            if (!(m_style_known && m_shown == rq.cursor_visible)) begin
               item_bytes.push_back(CH_ESC); item_bytes.push_back(CH_LB);
               item_bytes.push_back(CH_QM); item_bytes.push_back(CH_TWO);
               item_bytes.push_back(CH_FIVE);
               item_bytes.push_back(rq.cursor_visible ? CH_SHOW : CH_HIDE);
               m_shown = rq.cursor_visible;
               m_style_known = 1'b1;
            end
         end
         default: begin
            m_attr_known = 1'b0;
            m_pos_known = 1'b0;
            m_style_known = 1'b0;
         end
      endcase
      foreach (item_bytes[k]) begin
         w.out_byte = item_bytes[k];
         w.last_byte = (k == item_bytes.size() - 1);
         byte_queue.push_back(w);
      end
   endtask

   function automatic req_type make_req(input func_type f, input int r, input int c,
                                        input int a, input int ch, input bit v);
      req_type q;
      q.func = f;
      q.row = 8'(r);
      q.col = 8'(c);
      q.attr = 8'(a);
      q.char_code = 8'(ch);
      q.cursor_visible = v;
      return q;
   endfunction

   req_type rand_req;
   int      run_col;

   task automatic random_update();
      int pick;
      pick = $urandom_range(0, 99);
      rand_req = make_req(FUNC_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
      if (pick < 60) begin
         // stay on a run of cells so most writes need no repositioning
         rand_req.col = 8'(run_col);
         rand_req.row = 8'(run_col[0] ? 3 : 3);
         if (pick < 45) rand_req.attr = 8'h17;
         run_col = (run_col + 1) % 256;
         if ($urandom_range(0, 15) == 0) run_col = $urandom_range(0, 255);
      end else if (pick < 72) begin
         rand_req.func = FUNC_MOVE;
         if (pick < 66) begin rand_req.row = 8'd3; rand_req.col = 8'(run_col); end
      end else if (pick < 84) rand_req.func = FUNC_STYLE;
      else if (pick < 90) rand_req.func = FUNC_SYNC;
   endtask

   // Hand one update over when the block takes it, bursts and gaps in between.
   task automatic send(input req_type rq);
      req_push <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_full);
      encode_update(rq);
      if ($urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // directed table of updates; the first row's bytes are also checked by the feeding loop
   req_type dir_req [DIR_COUNT];
   initial begin
      dir_req = '{
         make_req(FUNC_STYLE, 0, 0, 0, 0, 1'b0),        // hide, unknown style
         make_req(FUNC_STYLE, 0, 0, 0, 0, 1'b0),        // same: nothing
         make_req(FUNC_STYLE, 0, 0, 0, 0, 1'b1),
         make_req(FUNC_WRITE, 0, 0, 8'h07, 8'h41, 1'b0), // full SGR, home
         make_req(FUNC_WRITE, 0, 1, 8'h07, 8'h00, 1'b0), // control code to dot
         make_req(FUNC_WRITE, 0, 2, 8'h07, 8'h7F, 1'b0), // delete to dot
         make_req(FUNC_WRITE, 0, 3, 8'hFF, 8'hFF, 1'b0), // bold, blink and bg change
         make_req(FUNC_WRITE, 0, 4, 8'h77, 8'h20, 1'b0), // bold and blink off
         make_req(FUNC_WRITE, 0, 5, 8'h71, 8'h1F, 1'b0), // fg only
         make_req(FUNC_WRITE, 255, 255, 8'h01, 8'h7E, 1'b0), // widest position
         make_req(FUNC_WRITE, 255, 0, 8'h01, 8'h80, 1'b0),   // column past end
         make_req(FUNC_MOVE, 9, 98, 0, 0, 1'b0),
         make_req(FUNC_MOVE, 9, 98, 0, 0, 1'b0),        // same place: nothing
         make_req(FUNC_MOVE, 99, 99, 0, 0, 1'b0),
         make_req(FUNC_SYNC, 0, 0, 0, 0, 1'b0),
         make_req(FUNC_WRITE, 99, 99, 8'h01, 8'h31, 1'b0), // full SGR after resync
         make_req(FUNC_STYLE, 0, 0, 0, 0, 1'b1),
         make_req(FUNC_WRITE, 0, 0, 8'h88, 8'hFE, 1'b0),
         make_req(FUNC_WRITE, 0, 1, 8'h80, 8'h30, 1'b0),   // bold off only
         make_req(FUNC_WRITE, 0, 2, 8'h00, 8'h30, 1'b0),   // blink off only
         make_req(FUNC_MOVE, 0, 3, 0, 0, 1'b0),
         make_req(FUNC_SYNC, 0, 0, 0, 0, 1'b0)
      };
   end

   initial begin
      int n;
      m_attr_known = 0; m_pos_known = 0; m_style_known = 0; m_shown = 0;
      m_attr = '0; m_row = '0; m_col = '0;
      m_bold = 0; m_blink = 0; m_fg = '0; m_bg = '0;
      run_col = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_COUNT; i++) begin
         send(dir_req[i]);
         // first row after reset: the bytes are known outright
         if (i == 0) begin
            if (item_bytes.size() != 6 || item_bytes[0] != CH_ESC
                || item_bytes[2] != CH_QM || item_bytes[5] != CH_HIDE) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("hide sequence predicted wrongly: expected %h %h %h %h %h %h",
                           CH_ESC, CH_LB, CH_QM, CH_TWO, CH_FIVE, CH_HIDE);
            end
         end
      end
      n = 0;
      while (n < 260) begin
         if (n == 120) hold_off = 1'b1;
         random_update();
         send(rand_req);
         n++;
      end
      req_push <= 1'b0;
      feeding_done = 1;
   end

   // receiver: own stall pattern plus one long hold-off
   initial begin
      int stall_ctr;
      stall_ctr = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (150) @(posedge clock);
            hold_off = 0;
         end
         stall_ctr++;
         rsp_pop <= !((stall_ctr % 23) < 6 && (stall_ctr % 97) > 40) && ($urandom_range(0, 4) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (byte_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected byte %h", rsp_data.out_byte);
         end else begin
            if (rsp_data.out_byte !== byte_queue[0].out_byte ||
                rsp_data.last_byte !== byte_queue[0].last_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("byte mismatch: expected %h/%b got %h/%b",
                           byte_queue[0].out_byte, byte_queue[0].last_byte,
                           rsp_data.out_byte, rsp_data.last_byte);
            end
            void'(byte_queue.pop_front());
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL ansi_sgr_cursor_encoder");
         $finish;
      end
   end

   initial begin
      wait (feeding_done);
      wait (byte_queue.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && byte_queue.size() == 0)
         $display("PASS ansi_sgr_cursor_encoder");
      else
         $display("FAIL ansi_sgr_cursor_encoder");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ase_pkg.sv
rtl/ase_front.sv
rtl/ase_queue.sv
rtl/ase_back.sv
rtl/ansi_sgr_cursor_encoder.sv
rtl/ase_checker.sv
tb/tb_top.sv
